// File: src/bat_pkg.sv
// shared constants, codes and result type for the buddy allocator
`timescale 1ns / 1ps
package bat_pkg;

	localparam int MIN_BLOCK_LOG2_DEF  = 7;
	localparam int LEAF_COUNT_LOG2_DEF = 10;
	localparam int OFFSET_W            = 17;
	localparam int REQ_W               = 24;

	localparam logic [3:0] SEG_LEVELS_RST = 4'd10;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	typedef struct packed {
		logic [OFFSET_W-1:0] block_offset;
		logic [1:0]          status;
	} bat_result_t;

endpackage

// File: src/bat_node.sv
// node index arithmetic of the implicit tree
`timescale 1ns / 1ps
module bat_node #(
	parameter int NW = 11
) (
	input  logic [NW-1:0] n,
	output logic [NW-1:0] left,
	output logic [NW-1:0] right,
	output logic [NW-1:0] parent,
	output logic [NW-1:0] sib,
	output logic [NW-1:0] left_left,
	output logic [NW-1:0] pair_left
);

	assign left      = {n[NW-2:0], 1'b1};
	assign right     = left + NW'(1);
	assign parent    = (n - NW'(1)) >> 1;
	assign sib       = n + NW'(1);
	assign left_left = {n[NW-3:0], 2'b11};
	// left child of the parent: n itself when n is a left child
	assign pair_left = n[0] ? n : n - NW'(1);

endmodule

// File: src/bat_ctrl.sv
// tree bit memory and the sequencer that walks it for alloc and free
`timescale 1ns / 1ps
module bat_ctrl import bat_pkg::*; #(
	parameter int MIN_BLOCK_LOG2  = MIN_BLOCK_LOG2_DEF,
	parameter int LEAF_COUNT_LOG2 = LEAF_COUNT_LOG2_DEF,
	parameter int LW              = $clog2(LEAF_COUNT_LOG2 + 2)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LW-1:0]       lv,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [REQ_W-1:0]    request_size,
	input  logic [OFFSET_W-1:0] free_offset,
	output logic                res_valid,
	input  logic                res_ready,
	output bat_result_t         res
);

	localparam int NW    = LEAF_COUNT_LOG2 + 1;
	localparam int NODES = (2 ** (LEAF_COUNT_LOG2 + 1)) - 1;
	localparam int UW    = OFFSET_W - MIN_BLOCK_LOG2;
	localparam int CW    = (MIN_BLOCK_LOG2 + LEAF_COUNT_LOG2 + 1 > REQ_W) ?
	                       MIN_BLOCK_LOG2 + LEAF_COUNT_LOG2 + 1 : REQ_W;
	localparam int SW    = (MIN_BLOCK_LOG2 + LEAF_COUNT_LOG2 > OFFSET_W) ?
	                       MIN_BLOCK_LOG2 + LEAF_COUNT_LOG2 : OFFSET_W;

	typedef enum logic [3:0] {
		CLEAR, IDLE, A_SIZE, A_N, A_L, A_R, A_UP, A_MARK,
		F_TZ, F_N0, F_L, F_R, F_UP, F_PL, F_PR, DONE
	} state_t;

	state_t              st_q, st_d;
	logic [NW-1:0]       n_q, n_d, clr_q, clr_d;
	logic [LW-1:0]       dp_q, dp_d, tgt_q, tgt_d, k_q, k_d, lv_q, lv_d;
	logic [REQ_W-1:0]    req_q, req_d;
	logic [UW-1:0]       u_q, u_d;
	bat_result_t         res_q, res_d;

	logic                used_q [NODES];
	logic                rbit_q;
	logic                mem_we, mem_wbit;
	logic [NW-1:0]       mem_waddr, mem_raddr;

	logic [NW-1:0]       left, right, parent, sib, left_left, pair_left;
	logic [UW-1:0]       u_in;
	logic [CW-1:0]       size_k;
	logic [LW-1:0]       dp_inc, fdepth;
	logic [NW-1:0]       fnode, pos;
	logic [SW-1:0]       off_w;

	bat_node #(.NW(NW)) u_node (
		.n(n_q), .left(left), .right(right), .parent(parent),
		.sib(sib), .left_left(left_left), .pair_left(pair_left)
	);

	assign u_in   = free_offset[OFFSET_W-1:MIN_BLOCK_LOG2];
	assign size_k = (CW'(1) << MIN_BLOCK_LOG2) << k_q;
	assign dp_inc = dp_q + LW'(1);
	assign fdepth = lv_q - k_q;
	assign fnode  = ((NW'(1) << fdepth) - NW'(1)) + NW'(u_q);
	assign pos    = n_q - ((NW'(1) << tgt_q) - NW'(1));
	assign off_w  = (SW'(pos) << MIN_BLOCK_LOG2) << k_q;

	assign in_ready  = (st_q == IDLE);
	assign res_valid = (st_q == DONE);
	assign res       = res_q;

	always_comb begin
		st_d      = st_q;
		n_d       = n_q;
		clr_d     = clr_q;
		dp_d      = dp_q;
		tgt_d     = tgt_q;
		k_d       = k_q;
		lv_d      = lv_q;
		req_d     = req_q;
		u_d       = u_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_wbit  = 1'b0;
		mem_waddr = n_q;
		mem_raddr = n_q;
		case (st_q)
			CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + NW'(1);
				if (clr_q == NW'(NODES - 1)) st_d = IDLE;
			end
			IDLE: begin
				if (in_valid) begin
					lv_d = lv;
					k_d  = '0;
					if (cmd == CMD_ALLOC) begin
						req_d = request_size;
						st_d  = A_SIZE;
					end else begin
						u_d   = u_in;
						res_d = '{block_offset: '0, status: ST_OK};
						if (free_offset[MIN_BLOCK_LOG2-1:0] != '0 || (u_in >> lv) != '0) begin
							res_d.status = ST_BADFREE;
							st_d         = DONE;
						end else begin
							st_d = F_TZ;
						end
					end
				end
			end
			A_SIZE: begin
				if (k_q > lv_q) begin
					res_d = '{block_offset: '0, status: ST_NOSPACE};
					st_d  = DONE;
				end else if (size_k >= CW'(req_q)) begin
					tgt_d     = lv_q - k_q;
					n_d       = '0;
					dp_d      = '0;
					mem_raddr = '0;
					st_d      = A_N;
				end else begin
					k_d = k_q + LW'(1);
				end
			end
			A_N: begin
				if (dp_q == tgt_q) begin
					if (!rbit_q) begin
						mem_we   = 1'b1;
						mem_wbit = 1'b1;
						res_d    = '{block_offset: off_w[OFFSET_W-1:0], status: ST_OK};
						st_d     = A_MARK;
					end else begin
						st_d = A_UP;
					end
				end else if (!rbit_q) begin
					n_d       = left;
					dp_d      = dp_inc;
					mem_raddr = left;
				end else begin
					mem_raddr = left;
					st_d      = A_L;
				end
			end
			A_L: begin
				if (rbit_q) begin
					n_d       = left;
					dp_d      = dp_inc;
					mem_raddr = left;
					st_d      = A_N;
				end else begin
					mem_raddr = right;
					st_d      = A_R;
				end
			end
			A_R: begin
				// a used node with both children clear is itself allocated
				if (rbit_q) begin
					n_d       = left;
					dp_d      = dp_inc;
					mem_raddr = left;
					st_d      = A_N;
				end else begin
					st_d = A_UP;
				end
			end
			A_UP: begin
				if (n_q == '0) begin
					res_d = '{block_offset: '0, status: ST_NOSPACE};
					st_d  = DONE;
				end else if (n_q[0]) begin
					n_d       = sib;
					mem_raddr = sib;
					st_d      = A_N;
				end else begin
					n_d  = parent;
					dp_d = dp_q - LW'(1);
				end
			end
			A_MARK: begin
				if (n_q == '0) begin
					st_d = DONE;
				end else begin
					mem_we    = 1'b1;
					mem_wbit  = 1'b1;
					mem_waddr = parent;
					n_d       = parent;
				end
			end
			F_TZ: begin
				// trailing zero count of the leaf index, capped at the level count
				if (k_q < lv_q && !u_q[0]) begin
					u_d = u_q >> 1;
					k_d = k_q + LW'(1);
				end else begin
					dp_d      = fdepth;
					n_d       = fnode;
					mem_raddr = fnode;
					st_d      = F_N0;
				end
			end
			F_N0: begin
				if (!rbit_q) begin
					res_d.status = ST_BADFREE;
					st_d         = DONE;
				end else if (dp_q < lv_q) begin
					mem_raddr = left;
					st_d      = F_L;
				end else begin
					mem_we = 1'b1;
					st_d   = F_UP;
				end
			end
			F_L: begin
				if (rbit_q) begin
					n_d  = left;
					dp_d = dp_inc;
					if (dp_inc < lv_q) begin
						mem_raddr = left_left;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = left;
						st_d      = F_UP;
					end
				end else begin
					mem_raddr = right;
					st_d      = F_R;
				end
			end
			F_R: begin
				if (rbit_q) begin
					res_d.status = ST_BADFREE;
					st_d         = DONE;
				end else begin
					mem_we = 1'b1;
					st_d   = F_UP;
				end
			end
			F_UP: begin
				if (n_q == '0) begin
					st_d = DONE;
				end else begin
					n_d       = parent;
					mem_raddr = pair_left;
					st_d      = F_PL;
				end
			end
			F_PL: begin
				if (rbit_q) begin
					st_d = DONE;
				end else begin
					mem_raddr = right;
					st_d      = F_PR;
				end
			end
			F_PR: begin
				if (rbit_q) begin
					st_d = DONE;
				end else begin
					mem_we = 1'b1;
					st_d   = F_UP;
				end
			end
			DONE: begin
				if (res_ready) st_d = IDLE;
			end
			default: st_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= CLEAR;
			clr_q <= '0;
			n_q   <= '0;
			dp_q  <= '0;
			tgt_q <= '0;
			k_q   <= '0;
			lv_q  <= '0;
		end else begin
			st_q  <= st_d;
			clr_q <= clr_d;
			n_q   <= n_d;
			dp_q  <= dp_d;
			tgt_q <= tgt_d;
			k_q   <= k_d;
			lv_q  <= lv_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		u_q   <= u_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) used_q[mem_waddr] <= mem_wbit;
		rbit_q <= used_q[mem_raddr];
	end

endmodule

// File: src/buddy_allocator_bitmap_tree.sv
// top level of the bitmap tree buddy allocator
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser cmd, tdata request_size, free_offset
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata status, block_offset
//  cfg       in   cfg_valid/cfg_ready            cfg_data segment_levels
//
// every tree read goes through the single read port of the bit memory, one read a cycle
// alloc: a search over block sizes, 1 to 3 reads per node visited in the
//   depth-first walk, then one write per level on the way back to the root
// free: trailing zero count, a walk down the left children, then a walk up through F_UP, F_PL and F_PR
// after reset a clearing pass over all 2^(L+1)-1 tree nodes runs before the first item
// a finished result waits in the output register while the next item starts
`timescale 1ns / 1ps
module buddy_allocator_bitmap_tree import bat_pkg::*; #(
	parameter int MIN_BLOCK_LOG2  = MIN_BLOCK_LOG2_DEF,
	parameter int LEAF_COUNT_LOG2 = LEAF_COUNT_LOG2_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // request_size[23:0], free_offset[40:24]
	input  logic        s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // status[1:0], block_offset[18:2]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data       // segment_levels
);

	localparam int LW = $clog2(LEAF_COUNT_LOG2 + 2);

	logic [3:0]    seg_levels_q;
	logic [LW-1:0] lv;
	logic          out_valid_q;
	bat_result_t   out_q, res;
	logic          res_valid, res_ready;

	assign cfg_ready = 1'b1;

	// levels beyond the tree depth fall back to the full tree
	assign lv = ({2'b00, seg_levels_q} > 6'(LEAF_COUNT_LOG2)) ?
	            LW'(LEAF_COUNT_LOG2) : LW'(seg_levels_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_levels_q <= SEG_LEVELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			seg_levels_q <= cfg_data;
		end
	end

	bat_ctrl #(
		.MIN_BLOCK_LOG2(MIN_BLOCK_LOG2),
		.LEAF_COUNT_LOG2(LEAF_COUNT_LOG2),
		.LW(LW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.lv(lv),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.cmd(s_axis_tuser),
		.request_size(s_axis_tdata[23:0]),
		.free_offset(s_axis_tdata[40:24]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, out_q.block_offset, out_q.status};

endmodule

// File: src/bat_checker.sv
// port-level checks on the allocator result stream
`timescale 1ns / 1ps
module bat_checker import bat_pkg::*; #(
	parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_NOSPACE ||
		                   m_axis_tdata[1:0] == ST_BADFREE))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[18:2] == '0)
		else $error("failed item carries an offset");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[MIN_BLOCK_LOG2+1:2] == '0)
		else $error("offset not aligned to the minimum block");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	// one item at a time: the input closes right after an accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input stayed open after an accepted item");

endmodule

bind buddy_allocator_bitmap_tree bat_checker #(.MIN_BLOCK_LOG2(MIN_BLOCK_LOG2)) u_bat_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

// File: verif/buddy_allocator_bitmap_tree_tb.sv
// self-checking testbench for the bitmap tree buddy allocator
`timescale 1ns / 1ps
module buddy_allocator_bitmap_tree_tb;
	import bat_pkg::*;

	localparam int MINB  = MIN_BLOCK_LOG2_DEF;
	localparam int LEAFL = LEAF_COUNT_LOG2_DEF;
	localparam int NODES = (2 << LEAFL) - 1;

	typedef struct {
		logic              cmd;
		logic [REQ_W-1:0]  size;
		logic [OFFSET_W-1:0] off;
		bit                typed;
		logic [1:0]        st;
		logic [OFFSET_W-1:0] boff;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;

	bit          tree_used [NODES];
	logic [3:0]  seg_levels;
	bat_result_t pending_results [$];
	int          live_blocks [$];
	int          mismatches = 0;
	int          tx_idle_pct = 36;
	int          rx_idle_pct = 79;
	int          rx_hold_cycles = 0;

	buddy_allocator_bitmap_tree dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#1s;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int eff_levels();
		return (seg_levels > LEAFL) ? LEAFL : int'(seg_levels);
	endfunction

	// leftmost depth-first placement, marks the path on success
	function automatic int place_block(int node, int depth, int target);
		int got;
		if (node >= NODES) return -1;
		if (depth == target) begin
			if (tree_used[node]) return -1;
			tree_used[node] = 1'b1;
			return node;
		end
		if (2 * node + 2 >= NODES) return -1;
		if (tree_used[node] && !tree_used[2*node+1] && !tree_used[2*node+2]) return -1;
		got = place_block(2 * node + 1, depth + 1, target);
		if (got < 0) got = place_block(2 * node + 2, depth + 1, target);
		if (got >= 0) tree_used[node] = 1'b1;
		return got;
	endfunction

	function automatic bat_result_t alloc_block(logic [REQ_W-1:0] req);
		bat_result_t r;
		int lv, k, d, node;
		longint unsigned boff;
		lv = eff_levels();
		r.status = ST_OK;
		r.block_offset = '0;
		for (k = 0; k <= lv; k++)
			if ((longint'(1) << (MINB + k)) >= longint'(req)) break;
		if (k > lv) begin
			r.status = ST_NOSPACE;
			return r;
		end
		d = lv - k;
		node = place_block(0, 0, d);
		if (node < 0) begin
			r.status = ST_NOSPACE;
			return r;
		end
		boff = longint'(node - ((1 << d) - 1)) << (MINB + k);
		r.block_offset = boff[OFFSET_W-1:0];
		return r;
	endfunction

	function automatic logic [1:0] free_block(logic [OFFSET_W-1:0] off);
		int lv, u, tz, depth, n;
		lv = eff_levels();
		if (off[MINB-1:0] != '0) return ST_BADFREE;
		u = int'(off) >> MINB;
		if (u >= (1 << lv)) return ST_BADFREE;
		tz = 0;
		if (u == 0) tz = lv;
		else while (tz < lv && ((u >> tz) & 1) == 0) tz++;
		depth = lv - tz;
		n = ((1 << depth) - 1) + (u >> (lv - depth));
		if (n >= NODES || !tree_used[n]) return ST_BADFREE;
		while (depth < lv) begin
			if (!tree_used[2*n+1]) break;
			n = 2 * n + 1;
			depth++;
		end
		if (depth < lv && tree_used[2*n+2]) return ST_BADFREE;
		tree_used[n] = 1'b0;
		while (n != 0) begin
			n = (n - 1) / 2;
			if (tree_used[2*n+1] || tree_used[2*n+2]) break;
			tree_used[n] = 1'b0;
		end
		return ST_OK;
	endfunction

	function automatic bat_result_t predict_result(logic cmd, logic [REQ_W-1:0] size,
			logic [OFFSET_W-1:0] off);
		bat_result_t r;
		if (cmd == CMD_FREE) begin
			r.status = free_block(off);
			r.block_offset = '0;
		end else begin
			r = alloc_block(size);
			if (r.status == ST_OK) live_blocks.push_back(int'(r.block_offset));
		end
		return r;
	endfunction

	// offers one item, predicts at acceptance
	task automatic send_item(logic cmd, logic [REQ_W-1:0] size, logic [OFFSET_W-1:0] off,
			bit typed, logic [1:0] st, logic [OFFSET_W-1:0] boff);
		bat_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {7'd0, off, size};
		do @(posedge clk); while (!s_axis_tready);
		r = predict_result(cmd, size, off);
		if (typed && (r.status !== st || r.block_offset !== boff))
			$display("directed row expectation differs from predictor: %0d/%0h vs %0d/%0h",
				st, boff, r.status, r.block_offset);
		if (typed) begin
			r.status = st;
			r.block_offset = boff;
		end
		pending_results.push_back(r);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_levels(logic [3:0] lv);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= lv;
		do @(posedge clk); while (!cfg_ready);
		seg_levels = lv;
		live_blocks.delete();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int lv, k, seg, idx, sel;
		logic [REQ_W-1:0] size;
		logic [OFFSET_W-1:0] off;
		lv = eff_levels();
		seg = 1 << (MINB + lv);
		size = REQ_W'($urandom);
		off = OFFSET_W'($urandom);
		sel = $urandom_range(99);
		if (sel < 50) begin
			k = $urandom_range(lv + 1);
			if ($urandom_range(99) < 6) size = REQ_W'($urandom);
			else if ($urandom_range(99) < 4) size = '0;
			else if (k == 0) size = REQ_W'($urandom_range(1 << MINB));
			else size = REQ_W'($urandom_range(1 << (MINB + k), (1 << (MINB + k - 1)) + 1));
			send_item(CMD_ALLOC, size, off, 0, ST_OK, '0);
		end else begin
			if (sel < 85 && live_blocks.size() != 0) begin
				idx = $urandom_range(live_blocks.size() - 1);
				off = OFFSET_W'(live_blocks[idx]);
				live_blocks.delete(idx);
			end else if (sel < 93) begin
				off = OFFSET_W'($urandom_range(seg - 1)) & ~OFFSET_W'((1 << MINB) - 1);
			end
			send_item(CMD_FREE, size, off, 0, ST_OK, '0);
		end
	endtask

	// receiver side: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		bat_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: %h", m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[1:0] !== want.status ||
						m_axis_tdata[18:2] !== want.block_offset) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d offset %h, expected %0d offset %h",
							m_axis_tdata[1:0], m_axis_tdata[18:2],
							want.status, want.block_offset);
				end
			end
		end
	end

	stim_row_t directed [$] = '{
		'{CMD_ALLOC, 24'd0,        17'd0,      1, ST_OK,      17'd0},
		'{CMD_ALLOC, 24'hFFFFFF,   17'h1FFFF,  1, ST_NOSPACE, 17'd0},
		'{CMD_ALLOC, 24'd131073,   17'd0,      1, ST_NOSPACE, 17'd0},
		'{CMD_ALLOC, 24'd131072,   17'd0,      0, ST_OK,      17'd0},
		'{CMD_FREE,  24'hFFFFFF,   17'd5,      1, ST_BADFREE, 17'd0},
		'{CMD_FREE,  24'd0,        17'h1FFFF,  1, ST_BADFREE, 17'd0},
		'{CMD_FREE,  24'd0,        17'd128,    0, ST_OK,      17'd0},
		'{CMD_FREE,  24'd0,        17'd0,      0, ST_OK,      17'd0},
		'{CMD_ALLOC, 24'd131072,   17'h1FFFF,  1, ST_OK,      17'd0},
		'{CMD_ALLOC, 24'd1,        17'd0,      1, ST_NOSPACE, 17'd0},
		'{CMD_FREE,  24'd0,        17'd0,      1, ST_OK,      17'd0},
		'{CMD_ALLOC, 24'd129,      17'd0,      0, ST_OK,      17'd0},
		'{CMD_ALLOC, 24'd100,      17'd0,      0, ST_OK,      17'd0},
		'{CMD_ALLOC, 24'd65536,    17'd0,      0, ST_OK,      17'd0},
		'{CMD_FREE,  24'd0,        17'd128,    0, ST_OK,      17'd0},
		'{CMD_FREE,  24'd0,        17'd256,    0, ST_OK,      17'd0},
		'{CMD_FREE,  24'd0,        17'd256,    0, ST_OK,      17'd0},
		'{CMD_FREE,  24'd0,        17'd130944, 0, ST_OK,      17'd0},
		'{CMD_ALLOC, 24'd65537,    17'd0,      0, ST_OK,      17'd0},
		'{CMD_FREE,  24'd0,        17'd65536,  0, ST_OK,      17'd0},
		'{CMD_FREE,  24'd0,        17'd0,      0, ST_OK,      17'd0}
	};

	initial begin
		int phase, i;
		int ph_levels [6] = '{10, 0, 15, 3, 10, 6};
		int ph_tx [6]     = '{36, 36, 79, 79, 0, 0};
		int ph_rx [6]     = '{79, 79, 36, 36, 0, 0};
		int ph_count [6]  = '{400, 100, 400, 150, 450, 200};
		seg_levels = SEG_LEVELS_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[j])
			send_item(directed[j].cmd, directed[j].size, directed[j].off,
				directed[j].typed, directed[j].st, directed[j].boff);

		for (phase = 0; phase < 6; phase++) begin
			write_levels(4'(ph_levels[phase]));
			tx_idle_pct = ph_tx[phase];
			rx_idle_pct = ph_rx[phase];
			for (i = 0; i < ph_count[phase]; i++) begin
				if (phase == 0 && i == 150) rx_hold_cycles = 3000;
				// at this point in phase 2 the sender waits for every outstanding result before going on
				if (phase == 2 && i == 200)
					while (pending_results.size() != 0) @(posedge clk);
				random_item();
			end
		end

		drain();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
